[rtl/core/crp_pkg.sv]
package crp_pkg;

  // canvas store geometry
  localparam int MaxWidth  = 256;
  localparam int MaxHeight = 256;
  localparam int FracBits  = 8;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int AddrW     = ColW + RowW;
  localparam int Depth     = MaxWidth * MaxHeight;

  // field widths
  localparam int DimW   = 9;
  localparam int SymW   = 8;
  localparam int CoordW = 20;
  localparam int RadW   = 19;
  localparam int IdxW   = 2;
  localparam int CfgW   = 9;

  // distance datapath widths
  localparam int PixColW = ColW + FracBits;
  localparam int PixRowW = RowW + FracBits;
  localparam int DiffW   = CoordW + 1;
  localparam int MagW    = CoordW;
  localparam int SqW     = 2 * MagW;
  localparam int DistW   = SqW + 1;
  localparam int RadSqW  = 2 * RadW;
  localparam int OneQ    = 1 << FracBits;

  // reset values of the configuration registers
  localparam logic [DimW-1:0] DimReset = DimW'(256);
  localparam logic [SymW-1:0] BgReset  = SymW'(32);

  // status codes
  localparam logic StatusOk  = 1'b0;
  localparam logic StatusErr = 1'b1;

  typedef enum logic [1:0] {
    KindDraw  = 2'd0,
    KindRead  = 2'd1,
    KindClear = 2'd2
  } kind_e;

  typedef enum logic [IdxW-1:0] {
    CfgWidth      = 2'd0,
    CfgHeight     = 2'd1,
    CfgBackground = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StScan,
    StDrain,
    StRead
  } state_e;

  typedef struct packed {
    logic [1:0]               kind;
    logic                     filled;
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic [RadW-1:0]          radius;
    logic [SymW-1:0]          paint_symbol;
    logic [7:0]               read_column;
    logic [7:0]               read_row;
  } cmd_t;

  typedef struct packed {
    logic [SymW-1:0] pixel_symbol;
    logic            status;
  } result_t;

  typedef struct packed {
    logic            painted;
    logic [SymW-1:0] symbol;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    entry_t           data;
  } mem_wr_t;

  typedef struct packed {
    logic             valid;
    logic [AddrW-1:0] addr;
  } pix_wr_t;

endpackage

[rtl/core/crp_canvas_mem.sv]
module crp_canvas_mem (
  input  logic                       clk_i,
  input  crp_pkg::mem_wr_t           wr_i,
  input  logic                       rd_en_i,
  input  logic [crp_pkg::AddrW-1:0]  rd_addr_i,
  output crp_pkg::entry_t            rd_data_o
);
  import crp_pkg::*;

  entry_t mem_q [Depth];
  entry_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/core/crp_scan.sv]
module crp_scan (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  crp_pkg::cmd_t             cmd_i,
  input  logic                      issue_i,
  input  logic [crp_pkg::ColW-1:0]  col_i,
  input  logic [crp_pkg::RowW-1:0]  row_i,
  output crp_pkg::pix_wr_t          wr_o,
  output logic                      busy_o
);
  import crp_pkg::*;

  // circle parameters held for the whole scan
  logic signed [CoordW-1:0] cx_q, cy_q;
  logic [RadSqW-1:0]        rr_q, rr1_q, rr_d, rr1_d;
  logic                     r1_neg_q, r1_neg_d, filled_q;
  logic [RadW-1:0]          r1;

  always_comb begin
    r1       = cmd_i.radius - RadW'(OneQ);
    r1_neg_d = cmd_i.radius < RadW'(OneQ);
    rr_d     = RadSqW'(cmd_i.radius) * RadSqW'(cmd_i.radius);
    rr1_d    = r1_neg_d ? '0 : RadSqW'(r1) * RadSqW'(r1);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      cx_q     <= cmd_i.center_x;
      cy_q     <= cmd_i.center_y;
      rr_q     <= rr_d;
      rr1_q    <= rr1_d;
      r1_neg_q <= r1_neg_d;
      filled_q <= cmd_i.filled;
    end
  end

  // stage 1: offsets from the center and their magnitudes
  logic signed [DiffW-1:0] px, py, dx, dy;
  logic [MagW-1:0]         adx_d, ady_d, adx_q, ady_q;
  logic [AddrW-1:0]        addr1_q, addr2_q, addr3_q;
  logic                    v1_q, v2_q, v3_q;

  always_comb begin
    px    = $signed({{(DiffW-PixColW){1'b0}}, col_i, {FracBits{1'b0}}});
    py    = $signed({{(DiffW-PixRowW){1'b0}}, row_i, {FracBits{1'b0}}});
    dx    = px - $signed({cx_q[CoordW-1], cx_q});
    dy    = py - $signed({cy_q[CoordW-1], cy_q});
    adx_d = dx[DiffW-1] ? MagW'(-dx) : MagW'(dx);
    ady_d = dy[DiffW-1] ? MagW'(-dy) : MagW'(dy);
  end

  // stage 2: squares
  logic [SqW-1:0] sqx_d, sqy_d, sqx_q, sqy_q;

  always_comb begin
    sqx_d = SqW'(adx_q) * SqW'(adx_q);
    sqy_d = SqW'(ady_q) * SqW'(ady_q);
  end

  // stage 3: squared distance
  logic [DistW-1:0] d_d, d_q;

  assign d_d = DistW'(sqx_q) + DistW'(sqy_q);

  always_ff @(posedge clk_i) begin
    adx_q   <= adx_d;
    ady_q   <= ady_d;
    addr1_q <= {row_i, col_i};
    sqx_q   <= sqx_d;
    sqy_q   <= sqy_d;
    addr2_q <= addr1_q;
    d_q     <= d_d;
    addr3_q <= addr2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= issue_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // outline and interior test against the squared radii
  logic inner, in_r, paint;

  always_comb begin
    inner = !r1_neg_q && (d_q <= DistW'(rr1_q));
    in_r  = d_q <= DistW'(rr_q);
    paint = (in_r && !inner) || (filled_q && inner);
  end

  assign wr_o.valid = v3_q && paint;
  assign wr_o.addr  = addr3_q;
  assign busy_o     = v1_q || v2_q || v3_q;

endmodule

[rtl/core/circle_raster_painter.sv]
// Circle raster painter: draws circles into a symbol canvas and reads pixels.
// Command channel: a beat on cmd_i is taken at a rising edge where start_i is
// high and busy_o is low. kind selects draw, read or clear.
// Result channel: every command gives one result beat on result_o, marked by
// done_o for exactly one cycle; the receiver cannot hold it off, and busy_o is
// already low in that cycle, so the next command may start there.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i (0 width,
// 1 height, 2 background symbol) at once; change it only while idle.
// Work done for each kind before done_o goes high:
//   draw: W*H pixels, one pixel a cycle through the distance pipeline
//     into the canvas memory write port (W, H the used canvas size)
//   read: one canvas memory read
//   clear: every memory entry, one memory entry written a cycle
//   zero radius, empty canvas, read outside canvas, unused kind: answered at once
// Reset: a clearing pass sweeps every entry of the canvas memory with busy_o
// high and gives no result; configuration writes are taken meanwhile.
module circle_raster_painter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  crp_pkg::cmd_t             cmd_i,
  output logic                      busy_o,
  output logic                      done_o,
  output crp_pkg::result_t          result_o,
  input  logic                      cfg_we_i,
  input  logic [crp_pkg::IdxW-1:0]  cfg_idx_i,
  input  logic [crp_pkg::CfgW-1:0]  cfg_wdata_i
);
  import crp_pkg::*;

  // configuration registers
  logic [DimW-1:0] width_q, height_q;
  logic [SymW-1:0] bg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimReset;
      height_q <= DimReset;
      bg_q     <= BgReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgWidth:      width_q  <= DimW'(cfg_wdata_i);
        CfgHeight:     height_q <= DimW'(cfg_wdata_i);
        CfgBackground: bg_q     <= cfg_wdata_i[SymW-1:0];
        default: ;
      endcase
    end
  end

  // used canvas size, saturated to the store
  logic [DimW-1:0] used_w, used_h;

  always_comb begin
    used_w = (width_q > DimW'(MaxWidth)) ? DimW'(MaxWidth) : width_q;
    used_h = (height_q > DimW'(MaxHeight)) ? DimW'(MaxHeight) : height_q;
  end

  state_e           state_q, state_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [AddrW-1:0] clr_cnt_q, clr_cnt_d;
  logic             clr_reply_q, clr_reply_d;
  logic [SymW-1:0]  sym_q, sym_d;
  logic             res_valid_q, res_valid_d;
  result_t          res_q, res_d;

  logic             accept, draw_go, read_ok, last_col, last_row, clr_last;
  logic             scan_load, scan_issue, scan_busy;
  pix_wr_t          scan_wr;
  mem_wr_t          mem_wr;
  logic             rd_en;
  entry_t           rd_data;

  assign busy_o = (state_q != StIdle);
  assign accept = start_i && !busy_o;

  always_comb begin
    draw_go  = (cmd_i.radius != '0) && (used_w != '0) && (used_h != '0);
    read_ok  = (DimW'(cmd_i.read_column) < used_w) && (DimW'(cmd_i.read_row) < used_h);
    last_col = (DimW'(col_q) == used_w - DimW'(1));
    last_row = (DimW'(row_q) == used_h - DimW'(1));
    clr_last = (clr_cnt_q == '1);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: begin
        if (clr_last) state_d = StIdle;
      end
      StIdle: begin
        if (accept) begin
          case (kind_e'(cmd_i.kind))
            KindDraw:  if (draw_go) state_d = StScan;
            KindRead:  if (read_ok) state_d = StRead;
            KindClear: state_d = StClear;
            default:   state_d = StIdle;
          endcase
        end
      end
      StScan: begin
        if (last_col && last_row) state_d = StDrain;
      end
      StDrain: begin
        if (!scan_busy) state_d = StIdle;
      end
      StRead: begin
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // counters, results and memory controls
  always_comb begin
    col_d        = col_q;
    row_d        = row_q;
    clr_cnt_d    = clr_cnt_q;
    clr_reply_d  = clr_reply_q;
    sym_d        = sym_q;
    res_valid_d  = 1'b0;
    res_d        = res_q;
    scan_load    = 1'b0;
    scan_issue   = 1'b0;
    rd_en        = 1'b0;
    mem_wr.en    = scan_wr.valid;
    mem_wr.addr  = scan_wr.addr;
    mem_wr.data  = '{painted: 1'b1, symbol: sym_q};
    unique case (state_q)
      StClear: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = clr_cnt_q;
        mem_wr.data = '0;
        clr_cnt_d   = clr_cnt_q + AddrW'(1);
        if (clr_last) begin
          clr_reply_d = 1'b0;
          if (clr_reply_q) begin
            res_valid_d = 1'b1;
            res_d       = '{pixel_symbol: '0, status: StatusOk};
          end
        end
      end
      StIdle: begin
        if (accept) begin
          col_d = '0;
          row_d = '0;
          res_d = '{pixel_symbol: '0, status: StatusOk};
          case (kind_e'(cmd_i.kind))
            KindDraw: begin
              scan_load = 1'b1;
              sym_d     = cmd_i.paint_symbol;
              if (!draw_go) begin
                res_valid_d  = 1'b1;
                res_d.status = (cmd_i.radius == '0) ? StatusErr : StatusOk;
              end
            end
            KindRead: begin
              rd_en = 1'b1;
              if (!read_ok) begin
                res_valid_d  = 1'b1;
                res_d.status = StatusErr;
              end
            end
            KindClear: begin
              clr_cnt_d   = '0;
              clr_reply_d = 1'b1;
            end
            default: res_valid_d = 1'b1;
          endcase
        end
      end
      StScan: begin
        scan_issue = 1'b1;
        if (last_col) begin
          col_d = '0;
          row_d = row_q + RowW'(1);
        end else begin
          col_d = col_q + ColW'(1);
        end
      end
      StDrain: begin
        if (!scan_busy) begin
          res_valid_d = 1'b1;
          res_d       = '{pixel_symbol: '0, status: StatusOk};
        end
      end
      StRead: begin
        res_valid_d = 1'b1;
        res_d.pixel_symbol = rd_data.painted ? rd_data.symbol : bg_q;
        res_d.status       = StatusOk;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      col_q       <= '0;
      row_q       <= '0;
      clr_cnt_q   <= '0;
      clr_reply_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_reply_q <= clr_reply_d;
      res_valid_q <= res_valid_d;
    end
  end

  // result and symbol payload
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    sym_q <= sym_d;
  end

  // pixel distance pipeline
  crp_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (scan_load),
    .cmd_i   (cmd_i),
    .issue_i (scan_issue),
    .col_i   (col_q),
    .row_i   (row_q),
    .wr_o    (scan_wr),
    .busy_o  (scan_busy)
  );

  // canvas store
  crp_canvas_mem u_mem (
    .clk_i     (clk_i),
    .wr_i      (mem_wr),
    .rd_en_i   (rd_en),
    .rd_addr_i ({cmd_i.read_row, cmd_i.read_column}),
    .rd_data_o (rd_data)
  );

  assign done_o   = res_valid_q;
  assign result_o = res_q;

endmodule

[rtl/core/crp_checker.sv]
module crp_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start_i,
  input crp_pkg::cmd_t             cmd_i,
  input logic                      busy_o,
  input logic                      done_o,
  input crp_pkg::result_t          result_o
);
  import crp_pkg::*;

  logic accept, kind_unused;

  assign accept      = start_i && !busy_o;
  assign kind_unused = (cmd_i.kind != KindDraw) && (cmd_i.kind != KindRead)
                       && (cmd_i.kind != KindClear);

  // an error beat never carries a symbol
  a_err_no_symbol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == StatusErr) |-> (result_o.pixel_symbol == '0))
    else $error("error result with nonzero symbol");

  // zero radius draw answers at once with error
  a_zero_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i.kind == KindDraw && cmd_i.radius == '0)
    |=> (done_o && result_o.status == StatusErr))
    else $error("zero radius draw not rejected");

  // a clear keeps the block busy and gives no beat at once
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i.kind == KindClear) |=> (busy_o && !done_o))
    else $error("clear did not start a sweep");

  // unused kind answers at once, ok and empty
  a_unused_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && kind_unused)
    |=> (done_o && result_o.status == StatusOk && result_o.pixel_symbol == '0))
    else $error("unused kind not answered");

endmodule

bind circle_raster_painter crp_checker u_crp_checker (.*);
